>>> rtl/sparse_row_tile_mac_int8_assert.svh
// Assertion macros for the sparse row tile MAC RTL (included by srtm_fifo).
// Expects the including module to have aclk and aresetn ports.
`ifndef SPARSE_ROW_TILE_MAC_INT8_ASSERT_SVH
`define SPARSE_ROW_TILE_MAC_INT8_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define SRTM_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("srtm assertion failed");
// Checked at every edge, reset included.
`define SRTM_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("srtm assertion failed");
`else
`define SRTM_ASSERT(label, prop)
`define SRTM_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> rtl/srtm_pkg.sv
// Package for the sparse row tile MAC: sizes, codes and the command type.
// No dependencies; used by every module of the block.
package srtm_pkg;

    localparam int LANES        = 8;
    localparam int PACKED_LANES = 8;
    localparam int LANE_IDX_W   = (LANES > 1) ? $clog2(LANES) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_NONZERO = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;

    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] CFG_ALPHA_SCALE  = 2'd1;
    localparam logic [1:0] CFG_BETA_SCALE   = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [LANES-1:0]  live;
        logic signed [7:0] sparse_value;
        logic [63:0]       dense_bytes;
        logic [2:0]        lane;
        logic [31:0]       old_output;
    } cmd_t;

endpackage

>>> rtl/srtm_front.sv
// Front end: takes requests, tracks the tile column and lane masks,
// drops requests with no effect. Depends on srtm_pkg.
module srtm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         column_count,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [15:0]         s_first_column,
    input  logic signed [7:0]   s_sparse_value,
    input  logic [63:0]         s_dense_bytes,
    input  logic [2:0]          s_lane_index,
    input  logic signed [31:0]  s_old_output,
    input  logic                q_full,
    output logic                q_push,
    output srtm_pkg::cmd_t      q_cmd
);

    logic [15:0]                 tile_column_reg;
    logic [15:0]                 tile_column_next;
    logic [srtm_pkg::LANES-1:0]  live_mask;
    logic                        finish_live;
    logic                        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // A lane is live when its column lies below the column count.
    always_comb begin
        for (int j = 0; j < srtm_pkg::LANES; j++) begin
            live_mask[j] = ({1'b0, tile_column_reg} + 17'(j)) < {1'b0, column_count};
        end
        finish_live = (int'(s_lane_index) < srtm_pkg::LANES) &&
                      (({1'b0, tile_column_reg} + 17'(s_lane_index)) < {1'b0, column_count});
    end

    always_comb begin
        q_cmd.kind         = s_opcode;
        q_cmd.live         = live_mask;
        q_cmd.sparse_value = s_sparse_value;
        q_cmd.dense_bytes  = s_dense_bytes;
        q_cmd.lane         = s_lane_index;
        q_cmd.old_output   = s_old_output;
        q_push             = 1'b0;
        tile_column_next   = tile_column_reg;
        if (accept) begin
            unique case (s_opcode)
                srtm_pkg::OP_START: begin
                    q_push           = 1'b1;
                    tile_column_next = s_first_column;
                end
                srtm_pkg::OP_NONZERO: begin
                    q_push = 1'b1;
                end
                srtm_pkg::OP_FINISH: begin
                    q_push = finish_live;
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_column_reg <= '0;
        end else begin
            tile_column_reg <= tile_column_next;
        end
    end

endmodule

>>> rtl/srtm_fifo.sv
// Short command queue between the front and back ends.
// Depends on srtm_pkg and the assertion header.
`include "sparse_row_tile_mac_int8_assert.svh"
module srtm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  srtm_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output srtm_pkg::cmd_t  head_cmd
);

    srtm_pkg::cmd_t                 entry_reg [srtm_pkg::QUEUE_DEPTH];
    logic [srtm_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [srtm_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [srtm_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [srtm_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [srtm_pkg::QCNT_W-1:0]    count_reg;
    logic [srtm_pkg::QCNT_W-1:0]    count_next;

    assign full       = (count_reg == srtm_pkg::QCNT_W'(srtm_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == srtm_pkg::QPTR_W'(srtm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == srtm_pkg::QPTR_W'(srtm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SRTM_ASSERT(a_count_bound, count_reg <= srtm_pkg::QCNT_W'(srtm_pkg::QUEUE_DEPTH))
    `SRTM_ASSERT(a_pop_nonempty, pop |-> head_valid)
    `SRTM_ASSERT(a_count_grows, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))

endmodule

>>> rtl/srtm_back.sv
// Back end: lane accumulators and the finish pipeline with output register.
// Depends on srtm_pkg.
module srtm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [31:0]         alpha_scale,
    input  logic [31:0]         beta_scale,
    input  logic                head_valid,
    input  srtm_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_out_lane,
    output logic signed [31:0]  m_new_output
);

    logic [31:0]                    sums_reg  [srtm_pkg::LANES];
    logic [31:0]                    sums_next [srtm_pkg::LANES];
    logic [31:0]                    prod_ext  [srtm_pkg::LANES];
    logic [srtm_pkg::LANE_IDX_W-1:0] sel_idx;

    logic        s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic        s1_ready, s2_ready, out_ready;
    logic [2:0]  s1_lane_reg, s2_lane_reg, out_lane_reg;
    logic [31:0] s1_sum_reg, s1_old_reg;
    logic [31:0] s2_alpha_prod_reg, s2_beta_prod_reg;
    logic [31:0] out_data_reg;
    logic        take_finish;

    // One 8x8 signed product per lane; lanes past the packed word add nothing.
    for (genvar j = 0; j < srtm_pkg::LANES; j++) begin : g_lane
        if (j < srtm_pkg::PACKED_LANES) begin : g_mul
            logic signed [15:0] prod;
            assign prod        = head_cmd.sparse_value * $signed(head_cmd.dense_bytes[8*j +: 8]);
            assign prod_ext[j] = 32'(prod);
        end else begin : g_none
            assign prod_ext[j] = '0;
        end
    end

    assign out_ready = !out_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign pop         = head_valid && ((head_cmd.kind != srtm_pkg::OP_FINISH) || s1_ready);
    assign take_finish = pop && (head_cmd.kind == srtm_pkg::OP_FINISH);
    assign sel_idx     = srtm_pkg::LANE_IDX_W'(head_cmd.lane);

    always_comb begin
        for (int j = 0; j < srtm_pkg::LANES; j++) begin
            sums_next[j] = sums_reg[j];
            if (pop && (head_cmd.kind == srtm_pkg::OP_START)) begin
                sums_next[j] = '0;
            end else if (pop && (head_cmd.kind == srtm_pkg::OP_NONZERO) &&
                         head_cmd.live[j]) begin
                sums_next[j] = sums_reg[j] + prod_ext[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < srtm_pkg::LANES; j++) begin
                sums_reg[j] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sums_reg <= sums_next;
            if (s1_ready) begin
                s1_valid_reg <= take_finish;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // A zero beta makes its product zero, so the old value drops out by itself.
    always_ff @(posedge aclk) begin
        if (s1_ready && take_finish) begin
            s1_lane_reg <= head_cmd.lane;
            s1_sum_reg  <= sums_reg[sel_idx];
            s1_old_reg  <= head_cmd.old_output;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_lane_reg       <= s1_lane_reg;
            s2_alpha_prod_reg <= alpha_scale * s1_sum_reg;
            s2_beta_prod_reg  <= beta_scale * s1_old_reg;
        end
        if (out_ready && s2_valid_reg) begin
            out_lane_reg <= s2_lane_reg;
            out_data_reg <= s2_alpha_prod_reg + s2_beta_prod_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_lane   = out_lane_reg;
    assign m_new_output = $signed(out_data_reg);

endmodule

>>> rtl/sparse_row_tile_mac_int8.sv
// Top level of the sparse row tile MAC with int8 operands.
// Depends on srtm_pkg, srtm_front, srtm_fifo and srtm_back.
//
// Usage: the block builds one tile of eight adjacent output columns of a
// sparse-times-dense product. Requests enter on the s_ channel (valid/ready)
// and carry an opcode: start tile (clears all lane sums and records the first
// column), nonzero (one int8 sparse value times eight packed int8 dense
// bytes, added into the live lanes), or finish (returns alpha * sum, plus
// beta * old output, for one lane). Only a finish of a live lane produces a
// request on the m_ channel; all other requests produce nothing.
// Configuration registers (column count, alpha, beta) are written through
// cfg_wr_en / cfg_index / cfg_wr_data, one write per cycle; the user must
// write them only while idle; the block does not enforce it. Throughput: one
// request per cycle while s_ready is high, set by the eight lane multiply-adds,
// which never stall a nonzero. A finish passes through the queue, sum select,
// the two 32x32 products and the final add into the output register.
// Reset (aresetn low, synchronous) clears the lane sums, the tile column,
// the queue and the pipeline, and restores column count 0, alpha 1, beta 0.
// When the receiver stalls, the three finish stages and then the four-entry
// queue fill and s_ready falls; starts and nonzeros queued ahead of the
// first waiting finish still drain.
module sparse_row_tile_mac_int8 (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [15:0]         s_first_column,
    input  logic signed [7:0]   s_sparse_value,
    input  logic [63:0]         s_dense_bytes,
    input  logic [2:0]          s_lane_index,
    input  logic signed [31:0]  s_old_output,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_out_lane,
    output logic signed [31:0]  m_new_output
);

    // Configuration registers; an unknown index is ignored.
    logic [15:0] column_count_reg;
    logic [31:0] alpha_scale_reg;
    logic [31:0] beta_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            alpha_scale_reg  <= 32'd1;
            beta_scale_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                srtm_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_wr_data[15:0];
                srtm_pkg::CFG_ALPHA_SCALE:  alpha_scale_reg  <= cfg_wr_data;
                srtm_pkg::CFG_BETA_SCALE:   beta_scale_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: classifies requests and pushes decoded commands.
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_head_valid;
    srtm_pkg::cmd_t q_push_cmd;
    srtm_pkg::cmd_t q_head_cmd;

    srtm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .column_count   (column_count_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_first_column (s_first_column),
        .s_sparse_value (s_sparse_value),
        .s_dense_bytes  (s_dense_bytes),
        .s_lane_index   (s_lane_index),
        .s_old_output   (s_old_output),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_push_cmd)
    );

    // The queue lets the front keep accepting while the back end waits.
    srtm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back end: accumulators and the finish pipeline ending in the output register.
    srtm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .alpha_scale  (alpha_scale_reg),
        .beta_scale   (beta_scale_reg),
        .head_valid   (q_head_valid),
        .head_cmd     (q_head_cmd),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_lane   (m_out_lane),
        .m_new_output (m_new_output)
    );

endmodule
